FILE: rtl/core/gdlg_pkg.sv
// Package for the GPU frequency-level governor: event codes, register map,
// payload and configuration structs, reset values and small helper functions.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package gdlg_pkg;

    localparam int FUNC_W    = 3;
    localparam int RAW_W     = 9;
    localparam int IDX_W     = 4;
    localparam int PCT_W     = 7;
    localparam int DEFER_W   = 8;
    localparam int HOLD_W    = 4;
    localparam int LVLS_W    = 5;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // Hard ceiling on the table: indexes are four bits wide.
    localparam int TABLE_CEIL = 16;

    localparam logic [PCT_W-1:0]   RST_LOW_THR    = 7'd25;
    localparam logic [PCT_W-1:0]   RST_HIGH_THR   = 7'd45;
    localparam logic [DEFER_W-1:0] RST_DEFER_LIM  = 8'd3;
    localparam logic               RST_BOOST_EN   = 1'b1;
    localparam logic [HOLD_W-1:0]  RST_BOOST_HOLD = 4'd3;
    localparam logic [LVLS_W-1:0]  RST_LEVELS     = 5'd16;
    localparam logic [IDX_W-1:0]   RST_REQ_LEVEL  = 4'd4;

    localparam logic [PCT_W-1:0]   PCT_MAX        = 7'd100;
    localparam logic [DEFER_W-1:0] DEFER_SAT      = 8'd255;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE     = 3'd0,
        FUNC_BOOST      = 3'd1,
        FUNC_LIMIT      = 3'd2,
        FUNC_PERF_REQ   = 3'd3,
        FUNC_SECOND_REQ = 3'd4,
        FUNC_POWER_ON   = 3'd5,
        FUNC_POWER_OFF  = 3'd6,
        FUNC_SLEEP_EXIT = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        REG_LOW_THR    = 3'd0,
        REG_HIGH_THR   = 3'd1,
        REG_DEFER_LIM  = 3'd2,
        REG_BOOST_EN   = 3'd3,
        REG_BOOST_HOLD = 3'd4,
        REG_LEVELS     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        t_func              func;
        logic [RAW_W-1:0]   raw_load;
        logic               clock_running;
        logic [IDX_W-1:0]   running_index;
        logic [IDX_W-1:0]   thermal_floor_index;
        logic [IDX_W-1:0]   request_value;
        logic               switch_accepted;
    } t_evt;

    typedef struct packed {
        logic               switch_request;
        logic [IDX_W-1:0]   switch_index;
        logic [PCT_W-1:0]   load_percent;
        logic [IDX_W-1:0]   planned_index;
    } t_res;

    typedef struct packed {
        logic [PCT_W-1:0]   load_low_threshold;
        logic [PCT_W-1:0]   load_high_threshold;
        logic [DEFER_W-1:0] defer_limit;
        logic               boost_enable;
        logic [HOLD_W-1:0]  boost_hold_samples;
        logic [LVLS_W-1:0]  levels_in_use;
    } t_cfg;

    // Effective table size: zero counts as one, and the size never exceeds cap.
    function automatic logic [LVLS_W-1:0] table_size(input logic [LVLS_W-1:0] lvls,
                                                     input logic [LVLS_W-1:0] cap);
        logic [LVLS_W-1:0] n;
        n = (lvls == '0) ? LVLS_W'(1) : lvls;
        if (n > cap) begin
            n = cap;
        end
        return n;
    endfunction

    // Converts a level count from the slowest end into a table index.
    function automatic logic [IDX_W-1:0] level_to_index(input logic [IDX_W-1:0] lvl,
                                                        input logic [LVLS_W-1:0] n);
        logic [LVLS_W-1:0] l;
        logic [LVLS_W-1:0] d;
        l = {1'b0, lvl};
        if (l >= n) begin
            l = n - LVLS_W'(1);
        end
        d = n - l - LVLS_W'(1);
        return d[IDX_W-1:0];
    endfunction

endpackage

FILE: rtl/core/gdlg_evt_if.sv
// Event channel interface: valid/ready handshake plus the event payload.
// Depends on gdlg_pkg for the field widths.
`timescale 1ns / 1ps

interface gdlg_evt_if
    import gdlg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [RAW_W-1:0]   raw_load;
    logic               clock_running;
    logic [IDX_W-1:0]   running_index;
    logic [IDX_W-1:0]   thermal_floor_index;
    logic [IDX_W-1:0]   request_value;
    logic               switch_accepted;

    modport source (
        output valid, func, raw_load, clock_running, running_index,
               thermal_floor_index, request_value, switch_accepted,
        input  ready
    );

    modport sink (
        input  valid, func, raw_load, clock_running, running_index,
               thermal_floor_index, request_value, switch_accepted,
        output ready
    );
endinterface

FILE: rtl/core/gdlg_res_if.sv
// Result channel interface: valid/ready handshake plus the result payload.
// Depends on gdlg_pkg for the field widths.
`timescale 1ns / 1ps

interface gdlg_res_if
    import gdlg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               switch_request;
    logic [IDX_W-1:0]   switch_index;
    logic [PCT_W-1:0]   load_percent;
    logic [IDX_W-1:0]   planned_index;

    modport source (
        output valid, switch_request, switch_index, load_percent, planned_index,
        input  ready
    );

    modport sink (
        input  valid, switch_request, switch_index, load_percent, planned_index,
        output ready
    );
endinterface

FILE: rtl/core/gdlg_cfg.sv
// APB-style configuration register file of the governor.
// Depends on gdlg_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps

module gdlg_cfg
    import gdlg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_LOW_THR:    n_cfg.load_low_threshold  = pwdata[PCT_W-1:0];
                REG_HIGH_THR:   n_cfg.load_high_threshold = pwdata[PCT_W-1:0];
                REG_DEFER_LIM:  n_cfg.defer_limit         = pwdata[DEFER_W-1:0];
                REG_BOOST_EN:   n_cfg.boost_enable        = pwdata[0];
                REG_BOOST_HOLD: n_cfg.boost_hold_samples  = pwdata[HOLD_W-1:0];
                REG_LEVELS:     n_cfg.levels_in_use       = pwdata[LVLS_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_LOW_THR:    prdata = PDATA_W'(r_cfg.load_low_threshold);
            REG_HIGH_THR:   prdata = PDATA_W'(r_cfg.load_high_threshold);
            REG_DEFER_LIM:  prdata = PDATA_W'(r_cfg.defer_limit);
            REG_BOOST_EN:   prdata = PDATA_W'(r_cfg.boost_enable);
            REG_BOOST_HOLD: prdata = PDATA_W'(r_cfg.boost_hold_samples);
            REG_LEVELS:     prdata = PDATA_W'(r_cfg.levels_in_use);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.load_low_threshold  <= RST_LOW_THR;
            r_cfg.load_high_threshold <= RST_HIGH_THR;
            r_cfg.defer_limit         <= RST_DEFER_LIM;
            r_cfg.boost_enable        <= RST_BOOST_EN;
            r_cfg.boost_hold_samples  <= RST_BOOST_HOLD;
            r_cfg.levels_in_use       <= RST_LEVELS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: rtl/core/gdlg_step.sv
// Governor state and the single-pass event logic that updates it.
// Depends on gdlg_pkg for the event and result structs and helper functions.
`timescale 1ns / 1ps

module gdlg_step
    import gdlg_pkg::*;
#(
    parameter int MAX_LEVELS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_advance,
    input  t_evt i_evt,
    input  t_cfg i_cfg,
    output t_res o_res
);

    localparam int LEVEL_CAP = (MAX_LEVELS < TABLE_CEIL) ? MAX_LEVELS : TABLE_CEIL;

    logic [IDX_W-1:0]   r_planned, n_planned;
    logic [IDX_W-1:0]   r_boost_lvl, n_boost_lvl;
    logic [IDX_W-1:0]   r_perf_req, n_perf_req;
    logic [IDX_W-1:0]   r_second_req, n_second_req;
    logic [DEFER_W-1:0] r_defer, n_defer;
    logic [HOLD_W-1:0]  r_boost_rem, n_boost_rem;
    logic [PCT_W-1:0]   r_last_load, n_last_load;

    logic [15:0]        w_prod;
    logic [7:0]         w_pct_raw;
    logic [PCT_W-1:0]   w_pct;
    logic               w_low_hit;
    logic               w_high_hit;
    logic [LVLS_W-1:0]  w_size;
    logic [LVLS_W-1:0]  w_top;
    logic signed [5:0]  w_cur;
    logic signed [5:0]  w_step;
    logic signed [5:0]  w_held;
    logic signed [5:0]  w_top_s;
    logic [IDX_W-1:0]   w_clamped;
    logic [DEFER_W-1:0] w_deferred;
    logic               w_boost_active;
    logic               w_hold;
    logic [IDX_W-1:0]   w_req_idx;
    logic [IDX_W-1:0]   w_on_floor;
    logic [IDX_W-1:0]   w_on_cap;
    logic [IDX_W-1:0]   w_on_idx;

    // Percent = raw * 100 / 256, saturated at 100.
    assign w_prod     = 16'(i_evt.raw_load) * 16'd100;
    assign w_pct_raw  = w_prod[15:8];
    assign w_pct      = (w_pct_raw > 8'(PCT_MAX)) ? PCT_MAX : w_pct_raw[PCT_W-1:0];
    assign w_low_hit  = w_pct <= i_cfg.load_low_threshold;
    assign w_high_hit = w_pct >= i_cfg.load_high_threshold;

    assign w_size = table_size(i_cfg.levels_in_use, LVLS_W'(LEVEL_CAP));
    assign w_top  = w_size - LVLS_W'(1);

    // Planned step one level slower or faster; the low test has priority.
    assign w_cur   = $signed({2'b00, i_evt.running_index});
    assign w_step  = w_low_hit ? (w_cur + 6'sd1) : (w_cur - 6'sd1);
    assign w_held  = (w_step < $signed({2'b00, i_evt.thermal_floor_index}))
                   ? $signed({2'b00, i_evt.thermal_floor_index}) : w_step;
    assign w_top_s = $signed({1'b0, w_top});

    always_comb begin
        if (w_held < 6'sd0) begin
            w_clamped = '0;
        end else if (w_held > w_top_s) begin
            w_clamped = w_top[IDX_W-1:0];
        end else begin
            w_clamped = w_held[IDX_W-1:0];
        end
    end

    assign w_deferred     = (r_defer < DEFER_SAT) ? (r_defer + DEFER_W'(1)) : DEFER_SAT;
    assign w_boost_active = r_boost_rem != '0;
    assign w_hold = w_boost_active ? (w_held >= $signed({2'b00, r_boost_lvl}))
                                   : (w_deferred < i_cfg.defer_limit);

    assign w_req_idx = level_to_index(i_evt.request_value, w_size);

    // Power on: planned level held by the thermal floor, capped by both requests.
    assign w_on_floor = (r_planned < i_evt.thermal_floor_index)
                      ? i_evt.thermal_floor_index : r_planned;
    assign w_on_cap   = (r_perf_req < r_second_req) ? r_perf_req : r_second_req;
    assign w_on_idx   = (w_on_floor > w_on_cap) ? w_on_cap : w_on_floor;

    always_comb begin
        n_planned    = r_planned;
        n_boost_lvl  = r_boost_lvl;
        n_perf_req   = r_perf_req;
        n_second_req = r_second_req;
        n_defer      = r_defer;
        n_boost_rem  = r_boost_rem;
        n_last_load  = r_last_load;
        o_res.switch_request = 1'b0;
        o_res.switch_index   = '0;

        unique case (i_evt.func)
            FUNC_SAMPLE: begin
                n_last_load = w_pct;
                if (i_evt.clock_running && (w_low_hit || w_high_hit)) begin
                    if (w_boost_active) begin
                        n_boost_rem = r_boost_rem - HOLD_W'(1);
                    end
                    if (w_hold) begin
                        n_defer = w_deferred;
                    end else if (w_held != w_cur) begin
                        n_planned = w_clamped;
                        if (w_clamped < r_boost_lvl) begin
                            n_boost_lvl = w_clamped;
                        end
                        n_defer = '0;
                    end
                end
            end
            FUNC_BOOST: begin
                if (i_cfg.boost_enable && (i_evt.request_value < i_evt.running_index)) begin
                    o_res.switch_request = 1'b1;
                    o_res.switch_index   = i_evt.request_value;
                    if (i_evt.switch_accepted) begin
                        n_boost_lvl = i_evt.request_value;
                        n_defer     = '0;
                        n_boost_rem = i_cfg.boost_hold_samples;
                    end
                end
            end
            FUNC_LIMIT: begin
                if (i_evt.running_index < i_evt.request_value) begin
                    o_res.switch_request = 1'b1;
                    o_res.switch_index   = i_evt.request_value;
                    if (i_evt.switch_accepted) begin
                        n_planned = i_evt.request_value;
                        n_defer   = '0;
                    end
                end
            end
            FUNC_PERF_REQ, FUNC_SECOND_REQ: begin
                if (i_evt.func == FUNC_PERF_REQ) begin
                    n_perf_req = w_req_idx;
                end else begin
                    n_second_req = w_req_idx;
                end
                if (w_req_idx < i_evt.running_index) begin
                    o_res.switch_request = 1'b1;
                    o_res.switch_index   = w_req_idx;
                end
            end
            FUNC_POWER_ON: begin
                o_res.switch_request = 1'b1;
                o_res.switch_index   = w_boost_active ? r_boost_lvl : w_on_idx;
            end
            FUNC_POWER_OFF: begin
                if (i_evt.clock_running) begin
                    o_res.switch_request = 1'b1;
                    o_res.switch_index   = w_top[IDX_W-1:0];
                end
                n_boost_rem = '0;
            end
            FUNC_SLEEP_EXIT: begin
                n_planned   = '0;
                n_defer     = '0;
                n_boost_rem = '0;
            end
            default: begin
                n_planned = r_planned;
            end
        endcase

        o_res.load_percent  = n_last_load;
        o_res.planned_index = n_planned;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planned    <= '0;
            r_boost_lvl  <= '0;
            r_perf_req   <= RST_REQ_LEVEL;
            r_second_req <= RST_REQ_LEVEL;
            r_defer      <= '0;
            r_boost_rem  <= '0;
            r_last_load  <= '0;
        end else if (i_advance) begin
            r_planned    <= n_planned;
            r_boost_lvl  <= n_boost_lvl;
            r_perf_req   <= n_perf_req;
            r_second_req <= n_second_req;
            r_defer      <= n_defer;
            r_boost_rem  <= n_boost_rem;
            r_last_load  <= n_last_load;
        end
    end

endmodule

FILE: rtl/core/gpu_dvfs_level_governor.sv
// Top level of the GPU frequency-level governor: event input register,
// result register and handshakes. Depends on gdlg_pkg, gdlg_evt_if,
// gdlg_res_if, gdlg_cfg and gdlg_step.
`timescale 1ns / 1ps

// Usage:
// Events arrive on i_evt, a valid/ready channel; each transfer carries one
// event kind (sample, boost, limit, level requests, power on/off, sleep exit)
// with its operands. Every event yields exactly one result transfer on o_res,
// in order: the switch request and index, the last load percent and the
// planned level index.
// The event lands in the input register at the transfer edge, and the result
// register is loaded from it once that register is empty or being read out,
// so each result passes through the input register and the result register.
// Throughput is one event per cycle. The single-pass compare-and-select logic
// between the two registers updates the governor state in the same cycle
// that the result register is loaded, so the following event already sees it.
// When the receiver stalls, the result register holds; one more event may
// wait in the input register, after which i_evt.ready drops until o_res moves.
// Configuration goes through the APB-style port (six registers at 4*index);
// the user writes it only while no event is in flight; the block does not
// enforce this. pready is always high. Synchronous active-low reset loads
// the register reset values, clears the governor state, empties both registers.
module gpu_dvfs_level_governor
    import gdlg_pkg::*;
#(
    parameter int MAX_LEVELS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gdlg_evt_if.sink           i_evt,
    gdlg_res_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg w_cfg;
    t_evt w_evt_in;
    t_evt r_evt;
    t_res w_res;
    t_res r_res;
    logic r_in_valid;
    logic r_out_valid;
    logic w_advance;
    logic w_take;

    gdlg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    gdlg_step #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_evt     (r_evt),
        .i_cfg     (w_cfg),
        .o_res     (w_res)
    );

    // The held event moves into the result register when that register is
    // empty or its result is being transferred out in this cycle.
    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_evt.ready = !r_in_valid || w_advance;
    assign w_take      = i_evt.valid && i_evt.ready;

    assign w_evt_in.func                = t_func'(i_evt.func);
    assign w_evt_in.raw_load            = i_evt.raw_load;
    assign w_evt_in.clock_running       = i_evt.clock_running;
    assign w_evt_in.running_index       = i_evt.running_index;
    assign w_evt_in.thermal_floor_index = i_evt.thermal_floor_index;
    assign w_evt_in.request_value       = i_evt.request_value;
    assign w_evt_in.switch_accepted     = i_evt.switch_accepted;

    assign o_res.valid          = r_out_valid;
    assign o_res.switch_request = r_res.switch_request;
    assign o_res.switch_index   = r_res.switch_index;
    assign o_res.load_percent   = r_res.load_percent;
    assign o_res.planned_index  = r_res.planned_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_evt <= w_evt_in;
        end
        if (w_advance) begin
            r_res <= w_res;
        end
    end

endmodule
